// ===== rtl/alle_pkg.sv =====
// shared types and constants for the array linked list engine
package alle_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int LINK_W     = 7;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 7;

    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INS_HEAD  = 2'd0,
        OP_DEL_AFTER = 2'd1,
        OP_INS_AFTER = 2'd2,
        OP_DUMP      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_LINK,
        S_INS_FIX,
        S_DEL_HEAD,
        S_DEL_NEXT,
        S_DEL_SKIP,
        S_DUMP_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RA_REF,
        RA_HEAD,
        RA_RLINK
    } t_rd_sel;

    typedef enum logic {
        WA_ALLOC,
        WA_REF
    } t_wa_sel;

    typedef enum logic [1:0] {
        WD_HEAD,
        WD_RLINK,
        WD_ALLOC
    } t_wd_sel;

    typedef enum logic {
        HEAD_ALLOC,
        HEAD_RLINK
    } t_head_sel;

    typedef struct packed {
        t_op                     op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    has_value;
        t_status                 status;
        logic                    last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      val_we;
        logic      link_we;
        t_wa_sel   wa_sel;
        t_wd_sel   wd_sel;
        logic      head_we;
        t_head_sel head_sel;
        logic      alloc_inc;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      emit;
        logic      emit_has;
        t_status   emit_status;
        logic      emit_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic pos_zero;
        logic pos_gt_alloc;
        logic full;
        logic head_null;
        logic rlink_null;
        logic dump_empty;
        logic dump_more;
    } t_dp_stat;

endpackage

// ===== rtl/alle_dp.sv =====
// datapath: node pool memories, head and allocation registers, result register
module alle_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alle_pkg::t_in_item i_item,
    input  alle_pkg::t_dp_cmd  i_cmd,
    output alle_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output alle_pkg::t_out_item o_result
);
    import alle_pkg::*;

    logic signed [VAL_W-1:0] r_node_values [POOL_DEPTH];
    logic [LINK_W-1:0]       r_node_links  [POOL_DEPTH];

    t_in_item                r_req;
    logic [LINK_W-1:0]       r_head;
    logic [CNT_W-1:0]        r_alloc;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [VAL_W-1:0] r_rd_value;
    logic [LINK_W-1:0]       r_rd_link;
    logic                    r_out_vld;
    t_out_item               r_out;

    logic [POS_W-1:0]  ref_full;
    logic [IDX_W-1:0]  ref_idx;
    logic [IDX_W-1:0]  alloc_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_link;
    logic [LINK_W-1:0] alloc_link;
    logic [LINK_W-1:0] pool_link;
    t_out_item         n_out;

    assign ref_full   = r_req.position - POS_W'(1);
    assign ref_idx    = ref_full[IDX_W-1:0];
    assign alloc_idx  = r_alloc[IDX_W-1:0];
    assign alloc_link = LINK_W'(r_alloc);
    assign pool_link  = LINK_W'(POOL_DEPTH);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_REF:   rd_addr = ref_idx;
            RA_HEAD:  rd_addr = r_head[IDX_W-1:0];
            RA_RLINK: rd_addr = r_rd_link[IDX_W-1:0];
            default:  rd_addr = ref_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wa_sel)
            WA_ALLOC: wr_addr = alloc_idx;
            WA_REF:   wr_addr = ref_idx;
            default:  wr_addr = alloc_idx;
        endcase
        unique case (i_cmd.wd_sel)
            WD_HEAD:  wr_link = r_head;
            WD_RLINK: wr_link = r_rd_link;
            WD_ALLOC: wr_link = alloc_link;
            default:  wr_link = r_head;
        endcase
    end

    // pool memories, one read and one write port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.val_we) begin
            r_node_values[alloc_idx] <= r_req.item_value;
        end
        if (i_cmd.link_we) begin
            r_node_links[wr_addr] <= wr_link;
        end
        if (i_cmd.rd_en) begin
            r_rd_value <= r_node_values[rd_addr];
            r_rd_link  <= r_node_links[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NULL_LINK;
            r_alloc <= '0;
        end else begin
            if (i_cmd.head_we) begin
                r_head <= (i_cmd.head_sel == HEAD_ALLOC) ? alloc_link : r_rd_link;
            end
            if (i_cmd.alloc_inc) begin
                r_alloc <= r_alloc + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_out.out_value = i_cmd.emit_has ? r_rd_value : '0;
        n_out.has_value = i_cmd.emit_has;
        n_out.status    = i_cmd.emit_status;
        n_out.last      = i_cmd.emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_stat.op           = r_req.op;
        o_stat.pos_zero     = (r_req.position == '0);
        o_stat.pos_gt_alloc = (r_req.position > POS_W'(r_alloc));
        o_stat.full         = (r_alloc >= CNT_W'(POOL_DEPTH));
        o_stat.head_null    = (r_head >= pool_link);
        o_stat.rlink_null   = (r_rd_link >= pool_link);
        o_stat.dump_empty   = (r_head >= pool_link) || (r_head >= alloc_link);
        // walk continues while the next link names an allocated node and room is left
        o_stat.dump_more    = (r_rd_link < pool_link) && (r_rd_link < alloc_link)
                              && (r_cnt < CNT_W'(POOL_DEPTH - 1));
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ===== rtl/alle_ctrl.sv =====
// controller: operation sequencing state machine
module alle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  alle_pkg::t_dp_stat i_stat,
    output logic               busy,
    output alle_pkg::t_dp_cmd  o_cmd
);
    import alle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    OP_INS_HEAD: n_state = S_IDLE;
                    OP_INS_AFTER: begin
                        if (i_stat.pos_zero || i_stat.pos_gt_alloc || i_stat.full) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_INS_LINK;
                        end
                    end
                    OP_DEL_AFTER: begin
                        priority if (i_stat.pos_gt_alloc) n_state = S_IDLE;
                        else if (i_stat.pos_zero) begin
                            n_state = i_stat.head_null ? S_IDLE : S_DEL_HEAD;
                        end else n_state = S_DEL_NEXT;
                    end
                    OP_DUMP: n_state = i_stat.dump_empty ? S_IDLE : S_DUMP_EMIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_INS_LINK:  n_state = S_INS_FIX;
            S_INS_FIX:   n_state = S_IDLE;
            S_DEL_HEAD:  n_state = S_IDLE;
            S_DEL_NEXT:  n_state = i_stat.rlink_null ? S_IDLE : S_DEL_SKIP;
            S_DEL_SKIP:  n_state = S_IDLE;
            S_DUMP_EMIT: n_state = i_stat.dump_more ? S_DUMP_EMIT : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.rd_sel      = RA_REF;
        o_cmd.wa_sel      = WA_ALLOC;
        o_cmd.wd_sel      = WD_HEAD;
        o_cmd.head_sel    = HEAD_ALLOC;
        o_cmd.emit_status = ST_OK;
        busy              = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    OP_INS_HEAD: begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.emit_status = ST_FULL;
                        end else begin
                            o_cmd.val_we    = 1'b1;
                            o_cmd.link_we   = 1'b1;
                            o_cmd.wa_sel    = WA_ALLOC;
                            o_cmd.wd_sel    = WD_HEAD;
                            o_cmd.head_we   = 1'b1;
                            o_cmd.head_sel  = HEAD_ALLOC;
                            o_cmd.alloc_inc = 1'b1;
                        end
                    end
                    OP_INS_AFTER: begin
                        priority if (i_stat.pos_zero || i_stat.pos_gt_alloc) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_BAD_POS;
                        end else if (i_stat.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_REF;
                        end
                    end
                    OP_DEL_AFTER: begin
                        priority if (i_stat.pos_gt_alloc) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_BAD_POS;
                        end else if (i_stat.pos_zero) begin
                            if (i_stat.head_null) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_last   = 1'b1;
                                o_cmd.emit_status = ST_NONE;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RA_HEAD;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_REF;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.dump_empty) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RA_HEAD;
                            o_cmd.cnt_clr = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                    end
                endcase
            end
            S_INS_LINK: begin
                // new node takes over the reference node's successor
                o_cmd.val_we  = 1'b1;
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = WA_ALLOC;
                o_cmd.wd_sel  = WD_RLINK;
            end
            S_INS_FIX: begin
                o_cmd.link_we   = 1'b1;
                o_cmd.wa_sel    = WA_REF;
                o_cmd.wd_sel    = WD_ALLOC;
                o_cmd.alloc_inc = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            S_DEL_HEAD: begin
                o_cmd.head_we   = 1'b1;
                o_cmd.head_sel  = HEAD_RLINK;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            S_DEL_NEXT: begin
                if (i_stat.rlink_null) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_NONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_RLINK;
                end
            end
            S_DEL_SKIP: begin
                o_cmd.link_we   = 1'b1;
                o_cmd.wa_sel    = WA_REF;
                o_cmd.wd_sel    = WD_RLINK;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            S_DUMP_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_has  = 1'b1;
                o_cmd.emit_last = !i_stat.dump_more;
                o_cmd.cnt_inc   = 1'b1;
                // fetch the next node straight from the link just read
                o_cmd.rd_en     = i_stat.dump_more;
                o_cmd.rd_sel    = RA_RLINK;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/array_linked_list_engine.sv =====
// array linked list engine: insert at head and rejected requests finish in the execute state;
// delete head reads the head node, then moves the head; delete after node reads the reference
// node, then its successor if any, then relinks; insert after reads the reference node, writes
// the new node, then links it in; dump reads the head node, then emits one value per cycle
// (empty list: one result). start is taken again in the cycle the final result shows; results
// cannot be stalled. synchronous active-low reset empties the list; pool memories are not cleared.
module array_linked_list_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  alle_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output alle_pkg::t_out_item o_result
);
    import alle_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    alle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    alle_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !busy)
        else $error("final result shown while still busy");

    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.has_value) |-> (o_result.out_value == '0))
        else $error("non-element result carries a value");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.has_value) |-> (o_result.status == ST_OK))
        else $error("element result carries an error status");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the array linked list engine
`timescale 1ns / 100ps

module tb_top;
    import alle_pkg::*;

    localparam int WDOG_LIMIT = 2000;
    localparam int TAIL_QUIET = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    array_linked_list_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_in_item  pend_cmds[$];
    t_out_item due_replies[$];

    // shadow copy of the node pool
    logic signed [VAL_W-1:0]  pool_val [POOL_DEPTH];
    logic [LINK_W-1:0]        pool_link [POOL_DEPTH];
    logic [LINK_W-1:0]        list_head = NULL_LINK;
    int                       alloc_cnt = 0;

    int   n_taken = 0;
    int   n_total = 0;
    int   quiet_from = 0;
    int   gap_left = 0;
    int   err_cnt = 0;
    int   stall_cycles = 0;
    logic xfer_in = 1'b0;

    function automatic void add_cmd(t_op op, int pos, logic [VAL_W-1:0] val);
        t_in_item cmd;
        cmd.op = op;
        cmd.position = pos[POS_W-1:0];
        cmd.item_value = val;
        pend_cmds.push_back(cmd);
    endfunction

    function automatic logic [LINK_W-1:0] next_of(logic [LINK_W-1:0] node);
        return (node < POOL_DEPTH) ? pool_link[node[IDX_W-1:0]] : NULL_LINK;
    endfunction

    // updates the shadow pool and queues the replies one command produces
    task automatic apply_list_op(input t_in_item cmd);
        t_out_item         rep;
        t_status           st;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] ref_node;
        int                n;
        rep = '0;
        st = ST_OK;
        if (cmd.op == OP_DUMP) begin
            cur = list_head;
            n = 0;
            if (cur >= POOL_DEPTH || cur >= alloc_cnt) begin
                rep.last = 1'b1;
                due_replies.push_back(rep);
            end else begin
                while (cur < POOL_DEPTH && cur < alloc_cnt && n < POOL_DEPTH) begin
                    nxt = next_of(cur);
                    n++;
                    rep.out_value = pool_val[cur[IDX_W-1:0]];
                    rep.has_value = 1'b1;
                    rep.last = !(nxt < POOL_DEPTH && nxt < alloc_cnt && n < POOL_DEPTH);
                    due_replies.push_back(rep);
                    cur = nxt;
                end
            end
        end else begin
            case (cmd.op)
                OP_INS_HEAD: begin
                    if (alloc_cnt >= POOL_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        pool_val[alloc_cnt[IDX_W-1:0]] = cmd.item_value;
                        pool_link[alloc_cnt[IDX_W-1:0]] = list_head;
                        list_head = alloc_cnt[LINK_W-1:0];
                        alloc_cnt++;
                    end
                end
                OP_INS_AFTER: begin
                    if (cmd.position == 0 || cmd.position > alloc_cnt) begin
                        st = ST_BAD_POS;
                    end else if (alloc_cnt >= POOL_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        ref_node = cmd.position - 1'b1;
                        pool_val[alloc_cnt[IDX_W-1:0]] = cmd.item_value;
                        pool_link[alloc_cnt[IDX_W-1:0]] = next_of(ref_node);
                        pool_link[ref_node[IDX_W-1:0]] = alloc_cnt[LINK_W-1:0];
                        alloc_cnt++;
                    end
                end
                default: begin
                    if (cmd.position > alloc_cnt) begin
                        st = ST_BAD_POS;
                    end else if (cmd.position == 0) begin
                        if (list_head >= POOL_DEPTH) st = ST_NONE;
                        else list_head = next_of(list_head);
                    end else begin
                        ref_node = cmd.position - 1'b1;
                        nxt = next_of(ref_node);
                        if (nxt >= POOL_DEPTH) st = ST_NONE;
                        else pool_link[ref_node[IDX_W-1:0]] = next_of(nxt);
                    end
                end
            endcase
            rep.status = st;
            rep.last = 1'b1;
            due_replies.push_back(rep);
        end
    endtask

    task automatic report_bad(input string what, input t_out_item want, input t_out_item got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t %s: exp val=%h has=%b st=%s last=%b, got val=%h has=%b st=%s last=%b",
                     $realtime, what, want.out_value, want.has_value, want.status.name(),
                     want.last, got.out_value, got.has_value, got.status.name(), got.last);
    endtask

    // result checking and prediction on the input transfer
    always @(posedge i_clk) begin : mon
        t_out_item want;
        xfer_in <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (due_replies.size() == 0) begin
                    report_bad("unexpected result", '0, o_result);
                end else begin
                    want = due_replies.pop_front();
                    if (o_result.out_value !== want.out_value
                        || o_result.has_value !== want.has_value
                        || o_result.status !== want.status
                        || o_result.last !== want.last)
                        report_bad("result mismatch", want, o_result);
                end
            end
            if (start && !busy) begin
                apply_list_op(i_item);
                n_taken++;
            end
        end
    end

    // command driver, changes inputs on the falling edge
    always @(negedge i_clk) begin : drv
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (xfer_in) begin
                pend_cmds.delete(0);
                // idle bursts, with some stretches left without any
                if (n_taken < quiet_from && ((n_taken / 40) % 3) != 2
                    && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            if (!start || xfer_in) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pend_cmds.size() > 0) begin
                    i_item <= pend_cmds[0];
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("array_linked_list_engine verification failed");
            $finish;
        end
    end

    initial begin
        int  pick;
        int  pos;
        int  ins_est;
        t_op op_sel;

        // empty list corner cases
        add_cmd(OP_DUMP, 0, 32'h0);
        add_cmd(OP_DEL_AFTER, 0, 32'hFFFF_FFFF);
        add_cmd(OP_DEL_AFTER, 1, 32'h0);
        add_cmd(OP_INS_AFTER, 0, 32'h1234_5678);
        add_cmd(OP_INS_AFTER, 1, 32'h1234_5678);
        // build a short list with extreme values
        add_cmd(OP_INS_HEAD, 127, 32'h7FFF_FFFF);
        add_cmd(OP_INS_HEAD, 0, 32'h8000_0000);
        add_cmd(OP_INS_AFTER, 1, 32'hFFFF_FFFF);
        add_cmd(OP_INS_AFTER, 3, 32'h0);
        add_cmd(OP_DUMP, 127, 32'hFFFF_FFFF);
        add_cmd(OP_DEL_AFTER, 1, 32'h0);
        // node 3 is out of the list now but still usable as a reference
        add_cmd(OP_INS_AFTER, 3, 32'h0000_0005);
        add_cmd(OP_DEL_AFTER, 3, 32'h0);
        add_cmd(OP_DEL_AFTER, 0, 32'h0);
        add_cmd(OP_DEL_AFTER, 4, 32'h0);
        add_cmd(OP_INS_AFTER, 127, 32'hA5A5_A5A5);
        add_cmd(OP_DEL_AFTER, 127, 32'h5A5A_5A5A);
        add_cmd(OP_DEL_AFTER, 6, 32'h0);
        add_cmd(OP_DUMP, 64, 32'h0);

        ins_est = 5;
        for (int i = 0; i < 255; i++) begin
            pick = $urandom_range(0, 99);
            if (i < 150)
                op_sel = (pick < 30) ? OP_INS_HEAD : (pick < 60) ? OP_INS_AFTER :
                         (pick < 85) ? OP_DEL_AFTER : OP_DUMP;
            else
                op_sel = (pick < 20) ? OP_INS_HEAD : (pick < 40) ? OP_INS_AFTER :
                         (pick < 75) ? OP_DEL_AFTER : OP_DUMP;
            if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 127);
            else pos = $urandom_range(0, ins_est + 1);
            if ((op_sel == OP_INS_HEAD || op_sel == OP_INS_AFTER) && ins_est < POOL_DEPTH)
                ins_est++;
            add_cmd(op_sel, pos, $urandom());
        end

        // pool should be exhausted by now
        add_cmd(OP_DUMP, 0, 32'h0);
        add_cmd(OP_INS_HEAD, 0, $urandom());
        add_cmd(OP_INS_AFTER, 64, $urandom());
        add_cmd(OP_INS_AFTER, 65, $urandom());
        add_cmd(OP_DEL_AFTER, 64, 32'h0);
        add_cmd(OP_DUMP, 0, 32'h0);

        n_total = pend_cmds.size();
        quiet_from = n_total - TAIL_QUIET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total) @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0)
            $display("array_linked_list_engine verification clean");
        else
            $display("array_linked_list_engine verification failed");
        $finish;
    end

endmodule
